// ----- rtl/fsct_pkg.sv -----
// fsct_pkg: shared types, codes and defaults for the fifo semaphore block
// no dependencies; imported by every module of the block

package fsct_pkg;

   // default sizes, overridable on the top level
   localparam int MAX_CLIENTS_DEF = 128;
   localparam int QUEUE_DEPTH_DEF = 512;
   localparam int ID_WIDTH_DEF    = 32;

   // fixed port widths
   localparam int REQ_W      = 2;
   localparam int CLIENT_W   = 32;
   localparam int STATUS_W   = 3;
   localparam int SLOT_OUT_W = 7;

   // request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_REGISTER   = 2'd0,
      REQ_UNREGISTER = 2'd1,
      REQ_ACQUIRE    = 2'd2,
      REQ_RELEASE    = 2'd3
   } req_code_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE          = 3'd0,
      ST_GRANTED       = 3'd1,
      ST_QUEUED        = 3'd2,
      ST_TABLE_FULL    = 3'd3,
      ST_NOT_FOUND     = 3'd4,
      ST_QUEUE_FULL    = 3'd5,
      ST_RELEASED_IDLE = 3'd6
   } status_type;

   // operation that waits on a table scan
   typedef enum logic [1:0] {
      OP_REGISTER,
      OP_UNREGISTER,
      OP_GRANT
   } op_type;

   // main controller states
   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_QREAD,
      CTL_SCAN,
      CTL_RESP
   } ctl_state_type;

   // table scan sequencer states
   typedef enum logic {
      TBL_IDLE,
      TBL_SCAN
   } tbl_state_type;

   // controller to table commands
   typedef struct packed {
      logic start;        // begin a scan of all slots
      logic find_free;    // scan for a free slot, else for the key
      logic set_valid;    // write key into the last hit slot and mark it used
      logic clear_valid;  // free the last hit slot
   } tbl_cmd_type;

   // table to controller result flags
   typedef struct packed {
      logic done;         // one-cycle pulse at the end of a scan
      logic found;        // a slot matched during the scan
   } tbl_res_type;

   // controller to queue commands
   typedef struct packed {
      logic push;
      logic pop;
   } q_cmd_type;

   // queue status
   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

endpackage

// ----- rtl/fsct_table.sv -----
// fsct_table: client table, id memory plus valid bits, with a scan sequencer
// that runs one shared compare unit over every slot; depends on fsct_pkg

module fsct_table #(
   parameter int MAX_CLIENTS = fsct_pkg::MAX_CLIENTS_DEF,
   parameter int ID_WIDTH    = fsct_pkg::ID_WIDTH_DEF,
   parameter int SLOT_W      = $clog2(MAX_CLIENTS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fsct_pkg::tbl_cmd_type cmd,
   input  logic [ID_WIDTH-1:0]   key,
   output fsct_pkg::tbl_res_type res,
   output logic [SLOT_W-1:0]     slot
);
   import fsct_pkg::*;

   localparam int CNT_W = $clog2(MAX_CLIENTS + 1);

   logic [ID_WIDTH-1:0] mem [MAX_CLIENTS];
   logic                valid_ff [MAX_CLIENTS];

   tbl_state_type       state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ID_WIDTH-1:0] key_ff, key_in;
   logic                free_ff, free_in;
   logic                found_ff, found_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                done_ff, done_in;

   // read stage
   logic                rd_live_ff;
   logic [ID_WIDTH-1:0] rd_id_ff;
   logic                rd_v_ff;
   logic [SLOT_W-1:0]   rd_idx_ff;

   logic                issue;
   logic [SLOT_W-1:0]   addr;
   logic                match;

   assign issue = (state_ff == TBL_SCAN) && (cnt_ff < CNT_W'(MAX_CLIENTS));
   assign addr  = cnt_ff[SLOT_W-1:0];

   // shared compare unit
   assign match = rd_live_ff && (free_ff ? !rd_v_ff : (rd_v_ff && (rd_id_ff == key_ff)));

   // id memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.set_valid) begin
         mem[slot_ff] <= key_ff;
      end
      if (issue) begin
         rd_id_ff <= mem[addr];
      end
   end

   // valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CLIENTS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (cmd.set_valid) begin
         valid_ff[slot_ff] <= 1'b1;
      end else if (cmd.clear_valid) begin
         valid_ff[slot_ff] <= 1'b0;
      end
   end

   // read stage payload
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_v_ff   <= valid_ff[addr];
         rd_idx_ff <= addr;
      end
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= TBL_IDLE;
         cnt_ff     <= '0;
         done_ff    <= 1'b0;
         found_ff   <= 1'b0;
         rd_live_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         done_ff    <= done_in;
         found_ff   <= found_in;
         rd_live_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      free_ff <= free_in;
      slot_ff <= slot_in;
   end

   // next state: issue every slot in turn, keep the highest hit
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      key_in   = key_ff;
      free_in  = free_ff;
      found_in = found_ff;
      slot_in  = slot_ff;
      done_in  = 1'b0;
      case (state_ff)
         TBL_IDLE: begin
            if (cmd.start) begin
               state_in = TBL_SCAN;
               cnt_in   = '0;
               key_in   = key;
               free_in  = cmd.find_free;
               found_in = 1'b0;
            end
         end
         TBL_SCAN: begin
            if (issue) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (match) begin
               found_in = 1'b1;
               slot_in  = rd_idx_ff;
            end
            // last slot has been compared
            if (rd_live_ff && (rd_idx_ff == SLOT_W'(MAX_CLIENTS - 1))) begin
               state_in = TBL_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            state_in = TBL_IDLE;
         end
      endcase
   end

   assign res.done  = done_ff;
   assign res.found = found_ff;
   assign slot      = slot_ff;

endmodule

// ----- rtl/fsct_queue.sv -----
// fsct_queue: ring buffer of waiting client ids in a memory with one write port
// and one registered read port, with head, tail and count registers; depends on fsct_pkg

module fsct_queue #(
   parameter int QUEUE_DEPTH = fsct_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_WIDTH    = fsct_pkg::ID_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fsct_pkg::q_cmd_type  cmd,
   input  logic [ID_WIDTH-1:0]  push_id,
   output logic [ID_WIDTH-1:0]  pop_id,
   output fsct_pkg::q_stat_type stat
);
   import fsct_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [ID_WIDTH-1:0] mem [QUEUE_DEPTH];
   logic [ID_WIDTH-1:0] rd_ff;
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [PTR_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   // memory: write at tail, registered read at head
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[tail_ff] <= push_id;
      end
      if (cmd.pop) begin
         rd_ff <= mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // pointer update with wrap at the depth
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (cmd.push) begin
         tail_in  = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         head_in  = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign pop_id     = rd_ff;
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));

endmodule

// ----- rtl/fifo_semaphore_with_client_table.sv -----
// fifo_semaphore_with_client_table: top level, request controller, response
// register, client table and wait queue; depends on fsct_pkg, fsct_table, fsct_queue
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/stall    | req_type, req_client_id
//   rsp_    | out       | rsp_valid/stall    | status, grant_client, grant_slot,
//           |           |                    | grant_found, slot_index
//
// register, unregister and every grant scan the client table one slot per
// cycle; a release that pops a waiter first reads the queue, then scans.
// a queued or queue_full acquire and an idle release skip the table scan.
// reset is synchronous; it empties the table and queue and frees the semaphore.
// a new request is taken once the previous one has its response registered,
// so a stalled response does not hold back the next request's work.

module fifo_semaphore_with_client_table #(
   parameter int MAX_CLIENTS = fsct_pkg::MAX_CLIENTS_DEF,
   parameter int QUEUE_DEPTH = fsct_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_WIDTH    = fsct_pkg::ID_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fsct_pkg::REQ_W-1:0]    req_type,
   input  logic [fsct_pkg::CLIENT_W-1:0] req_client_id,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fsct_pkg::STATUS_W-1:0] rsp_status,
   output logic [fsct_pkg::CLIENT_W-1:0] rsp_grant_client,
   output logic [fsct_pkg::SLOT_OUT_W-1:0] rsp_grant_slot,
   output logic                          rsp_grant_found,
   output logic [fsct_pkg::SLOT_OUT_W-1:0] rsp_slot_index
);
   import fsct_pkg::*;

   localparam int SLOT_W = $clog2(MAX_CLIENTS);

   ctl_state_type           state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [ID_WIDTH-1:0]     key_ff, key_in;
   logic                    held_ff, held_in;

   status_type              res_status_ff, res_status_in;
   logic [CLIENT_W-1:0]     res_client_ff, res_client_in;
   logic [SLOT_OUT_W-1:0]   res_slot_ff, res_slot_in;
   logic                    res_found_ff, res_found_in;
   logic [SLOT_OUT_W-1:0]   res_index_ff, res_index_in;

   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   logic [CLIENT_W-1:0]     rsp_client_ff;
   logic [SLOT_OUT_W-1:0]   rsp_slot_ff;
   logic                    rsp_found_ff;
   logic [SLOT_OUT_W-1:0]   rsp_index_ff;

   tbl_cmd_type             tbl_cmd;
   tbl_res_type             tbl_res;
   logic [ID_WIDTH-1:0]     tbl_key;
   logic [SLOT_W-1:0]       tbl_slot;
   q_cmd_type               q_cmd;
   q_stat_type              q_stat;
   logic [ID_WIDTH-1:0]     q_pop_id;

   logic [63:0]             id_wide;
   logic [ID_WIDTH-1:0]     req_id;
   logic [63:0]             key_wide;
   logic [CLIENT_W-1:0]     key_client;
   logic [63:0]             slot_wide;
   logic [SLOT_OUT_W-1:0]   slot_narrow;
   logic                    accept;
   logic                    rsp_load;

   // id kept at ID_WIDTH bits, reported at the port width
   assign id_wide     = {32'b0, req_client_id};
   assign req_id      = id_wide[ID_WIDTH-1:0];
   assign key_wide    = 64'(key_ff);
   assign key_client  = key_wide[CLIENT_W-1:0];
   assign slot_wide   = 64'(tbl_slot);
   assign slot_narrow = slot_wide[SLOT_OUT_W-1:0];

   assign req_stall = (state_ff != CTL_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_load  = (state_ff == CTL_RESP) && (!rsp_valid_ff || !rsp_stall);

   fsct_table #(
      .MAX_CLIENTS (MAX_CLIENTS),
      .ID_WIDTH    (ID_WIDTH),
      .SLOT_W      (SLOT_W)
   ) u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (tbl_cmd),
      .key   (tbl_key),
      .res   (tbl_res),
      .slot  (tbl_slot)
   );

   fsct_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .cmd     (q_cmd),
      .push_id (req_id),
      .pop_id  (q_pop_id),
      .stat    (q_stat)
   );

   // controller registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
         held_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_client_ff <= res_client_in;
      res_slot_ff   <= res_slot_in;
      res_found_ff  <= res_found_in;
      res_index_ff  <= res_index_in;
   end

   // request sequencing
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      held_in       = held_ff;
      res_status_in = res_status_ff;
      res_client_in = res_client_ff;
      res_slot_in   = res_slot_ff;
      res_found_in  = res_found_ff;
      res_index_in  = res_index_ff;
      tbl_cmd       = '0;
      tbl_key       = req_id;
      q_cmd         = '0;
      case (state_ff)
         CTL_IDLE: begin
            if (accept) begin
               key_in        = req_id;
               res_status_in = ST_DONE;
               res_client_in = '0;
               res_slot_in   = '0;
               res_found_in  = 1'b0;
               res_index_in  = '0;
               case (req_code_type'(req_type))
                  REQ_REGISTER: begin
                     op_in             = OP_REGISTER;
                     tbl_cmd.start     = 1'b1;
                     tbl_cmd.find_free = 1'b1;
                     state_in          = CTL_SCAN;
                  end
                  REQ_UNREGISTER: begin
                     op_in         = OP_UNREGISTER;
                     tbl_cmd.start = 1'b1;
                     state_in      = CTL_SCAN;
                  end
                  REQ_ACQUIRE: begin
                     if (!held_ff) begin
                        held_in       = 1'b1;
                        op_in         = OP_GRANT;
                        tbl_cmd.start = 1'b1;
                        state_in      = CTL_SCAN;
                     end else if (q_stat.full) begin
                        res_status_in = ST_QUEUE_FULL;
                        state_in      = CTL_RESP;
                     end else begin
                        q_cmd.push    = 1'b1;
                        res_status_in = ST_QUEUED;
                        state_in      = CTL_RESP;
                     end
                  end
                  REQ_RELEASE: begin
                     if (!q_stat.empty) begin
                        held_in   = 1'b1;
                        q_cmd.pop = 1'b1;
                        state_in  = CTL_QREAD;
                     end else begin
                        held_in       = 1'b0;
                        res_status_in = ST_RELEASED_IDLE;
                        state_in      = CTL_RESP;
                     end
                  end
                  default: begin
                     state_in = CTL_RESP;
                  end
               endcase
            end
         end
         // popped waiter is the new holder; look up its slot
         CTL_QREAD: begin
            key_in        = q_pop_id;
            tbl_key       = q_pop_id;
            op_in         = OP_GRANT;
            tbl_cmd.start = 1'b1;
            state_in      = CTL_SCAN;
         end
         CTL_SCAN: begin
            if (tbl_res.done) begin
               state_in = CTL_RESP;
               case (op_ff)
                  OP_REGISTER: begin
                     if (tbl_res.found) begin
                        tbl_cmd.set_valid = 1'b1;
                        res_status_in     = ST_DONE;
                        res_index_in      = slot_narrow;
                     end else begin
                        res_status_in = ST_TABLE_FULL;
                     end
                  end
                  OP_UNREGISTER: begin
                     if (tbl_res.found) begin
                        tbl_cmd.clear_valid = 1'b1;
                        res_status_in       = ST_DONE;
                        res_index_in        = slot_narrow;
                     end else begin
                        res_status_in = ST_NOT_FOUND;
                     end
                  end
                  OP_GRANT: begin
                     res_status_in = ST_GRANTED;
                     res_client_in = key_client;
                     res_found_in  = tbl_res.found;
                     res_slot_in   = tbl_res.found ? slot_narrow : '0;
                  end
                  default: begin
                     res_status_in = ST_DONE;
                  end
               endcase
            end
         end
         CTL_RESP: begin
            if (rsp_load) begin
               state_in = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_client_ff <= res_client_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_index_ff  <= res_index_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_grant_client = rsp_client_ff;
   assign rsp_grant_slot   = rsp_slot_ff;
   assign rsp_grant_found  = rsp_found_ff;
   assign rsp_slot_index   = rsp_index_ff;

endmodule

// ----- rtl/fsct_checker.sv -----
// fsct_checker: port-level assertions for the fifo semaphore block, bound to
// the top level; depends on fsct_pkg and fifo_semaphore_with_client_table

module fsct_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [fsct_pkg::STATUS_W-1:0]   rsp_status,
   input logic [fsct_pkg::CLIENT_W-1:0]   rsp_grant_client,
   input logic [fsct_pkg::SLOT_OUT_W-1:0] rsp_grant_slot,
   input logic                            rsp_grant_found,
   input logic [fsct_pkg::SLOT_OUT_W-1:0] rsp_slot_index
);
   import fsct_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_grant_client) && $stable(rsp_grant_slot)
         && $stable(rsp_grant_found) && $stable(rsp_slot_index))
      else $error("response changed while stalled");

   // block is busy right after taking a request
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in progress");

   // grant fields are zero unless granted
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_GRANTED) |->
         !rsp_grant_found && (rsp_grant_client == '0) && (rsp_grant_slot == '0))
      else $error("grant fields set on a non-grant response");

   // slot index only on register or unregister success
   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_DONE) |-> (rsp_slot_index == '0))
      else $error("slot index set on a response other than done");

endmodule

bind fifo_semaphore_with_client_table fsct_checker u_fsct_checker (.*);
